FILE: rtl/dq_pkg.sv
// Shared constants, codes and types for the double-ended queue.
`default_nettype none
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_WIDTH  = $clog2(DEPTH + 1);

  localparam int ACTION_WIDTH = 3;
  localparam int STATUS_WIDTH = 2;
  localparam int VALUE_WIDTH  = 32;
  localparam int COUNT_WIDTH  = 5;

  localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_WIDTH-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_WIDTH-1:0] ACT_PEEK_FRONT = 3'd4;
  localparam logic [ACTION_WIDTH-1:0] ACT_PEEK_BACK  = 3'd5;
  localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR      = 3'd6;

  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

  // Access issued to the slot memory in the cycle a request is taken.
  typedef struct packed {
    logic                  we;
    logic [ADDR_WIDTH-1:0] waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_WIDTH-1:0] raddr;
  } ram_req_t;

  function automatic logic [ADDR_WIDTH-1:0] idx_next(input logic [ADDR_WIDTH-1:0] i);
    return (i == ADDR_WIDTH'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [ADDR_WIDTH-1:0] idx_prev(input logic [ADDR_WIDTH-1:0] i);
    return (i == '0) ? ADDR_WIDTH'(DEPTH - 1) : i - 1'b1;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dq_ctrl.sv
// Index and occupancy control for the queue: decodes a request into one slot access.
`default_nettype none
module dq_ctrl (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire logic [dq_pkg::ACTION_WIDTH-1:0]    action,
  input  wire logic [dq_pkg::DATA_WIDTH-1:0]      word,
  output dq_pkg::ram_req_t                        ram_req,
  output logic                                    done,
  output logic                                    show_data,
  output logic [dq_pkg::STATUS_WIDTH-1:0]         status,
  output logic [dq_pkg::CNT_WIDTH-1:0]            occ
);

  logic [dq_pkg::ADDR_WIDTH-1:0]   front, front_next;
  logic [dq_pkg::ADDR_WIDTH-1:0]   back, back_next;
  logic [dq_pkg::CNT_WIDTH-1:0]    occ_next;
  logic [dq_pkg::STATUS_WIDTH-1:0] status_next;
  logic                            show_next;
  logic                            is_full;
  logic                            is_empty;

  assign is_full  = (occ == dq_pkg::CNT_WIDTH'(dq_pkg::DEPTH));
  assign is_empty = (occ == '0);

  always_comb begin
    front_next    = front;
    back_next     = back;
    occ_next      = occ;
    status_next   = dq_pkg::ST_OK;
    show_next     = 1'b0;
    ram_req       = '0;
    ram_req.wdata = word;
    unique case (action) inside
      dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
        if (is_full) begin
          status_next = dq_pkg::ST_FULL;
        end else begin
          ram_req.we = accept;
          occ_next   = occ + 1'b1;
          if (action == dq_pkg::ACT_PUSH_FRONT) begin
            front_next    = dq_pkg::idx_prev(front);
            ram_req.waddr = front_next;
          end else begin
            ram_req.waddr = back;
            back_next     = dq_pkg::idx_next(back);
          end
        end
      end
      dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK,
      dq_pkg::ACT_PEEK_FRONT, dq_pkg::ACT_PEEK_BACK: begin
        if (is_empty) begin
          status_next = dq_pkg::ST_EMPTY;
        end else begin
          ram_req.re = accept;
          show_next  = 1'b1;
          if (action == dq_pkg::ACT_POP_FRONT) begin
            ram_req.raddr = front;
            front_next    = dq_pkg::idx_next(front);
            occ_next      = occ - 1'b1;
          end else if (action == dq_pkg::ACT_POP_BACK) begin
            back_next     = dq_pkg::idx_prev(back);
            ram_req.raddr = back_next;
            occ_next      = occ - 1'b1;
          end else if (action == dq_pkg::ACT_PEEK_FRONT) begin
            ram_req.raddr = front;
          end else begin
            ram_req.raddr = dq_pkg::idx_prev(back);
          end
        end
      end
      dq_pkg::ACT_CLEAR: begin
        front_next = '0;
        back_next  = '0;
        occ_next   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      back      <= '0;
      occ       <= '0;
      done      <= 1'b0;
      show_data <= 1'b0;
      status    <= dq_pkg::ST_OK;
    end else begin
      done <= accept;
      if (accept) begin
        front     <= front_next;
        back      <= back_next;
        occ       <= occ_next;
        show_data <= show_next;
        status    <= status_next;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue: request port, slot memory and control.
// Usage:
//   A request is taken at a rising clock edge where start is high and busy is low.
//   It carries an action (push front/back, pop front/back, peek front/back, clear)
//   and value_in, which only the pushes store.
//   Each request gives exactly one result on value_out, status and count, shown
//   for one clock cycle with done high; the receiver takes it at the end of that
//   cycle and cannot hold it off.
//   The result of a request taken at one edge is on the outputs during the
//   following cycle. busy stays low, so a request can be taken at every edge,
//   one per cycle; the slot memory is written or read at most once per request
//   at the edge where it is taken, so back-to-back requests never race on
//   a slot.
//   value_out is zero unless a pop or peek succeeded. status reports an empty
//   queue on pop or peek, and a full queue on push; a refused request changes
//   nothing. count is the number of stored words after the request.
//   Reset (rst, synchronous) empties the queue; the slot contents are not cleared
//   and no clearing pass is needed, since only occupied slots are ever read.
`default_nettype none
module double_ended_queue (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [dq_pkg::ACTION_WIDTH-1:0]    action,
  input  wire logic [dq_pkg::VALUE_WIDTH-1:0]     value_in,
  output logic                                    done,
  output logic      [dq_pkg::VALUE_WIDTH-1:0]     value_out,
  output logic      [dq_pkg::STATUS_WIDTH-1:0]    status,
  output logic      [dq_pkg::COUNT_WIDTH-1:0]     count
);

  dq_pkg::ram_req_t                ram_req;
  logic                            accept;
  logic                            show_data;
  logic [dq_pkg::DATA_WIDTH-1:0]   rdata;
  logic [dq_pkg::CNT_WIDTH-1:0]    occ;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (action),
    .word      (value_in[dq_pkg::DATA_WIDTH-1:0]),
    .ram_req   (ram_req),
    .done      (done),
    .show_data (show_data),
    .status    (status),
    .occ       (occ)
  );

  dq_ram #(
    .WIDTH (dq_pkg::DATA_WIDTH),
    .DEPTH (dq_pkg::DEPTH),
    .AW    (dq_pkg::ADDR_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  // A refused or non-reading transaction shows zero instead of stale read data.
  assign value_out = show_data ? dq_pkg::VALUE_WIDTH'(rdata) : '0;
  assign count     = dq_pkg::COUNT_WIDTH'(occ);

endmodule
`default_nettype wire

FILE: dv/double_ended_queue_tb.sv
// Testbench for double_ended_queue: directed table and random requests checked by a predictor.
`timescale 1ns / 1ps
module double_ended_queue_tb;
  import dq_pkg::*;

  // Action code 7 is unused and must behave as a no-op.
  localparam logic [ACTION_WIDTH-1:0] ACT_NOP = 3'd7;
  localparam int DIR_ROWS = 18;
  localparam int RAND_PER_PHASE = 460;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0]  value;
    logic [STATUS_WIDTH-1:0] status;
    logic [COUNT_WIDTH-1:0]  count;
  } dq_result_t;

  typedef struct packed {
    logic [ACTION_WIDTH-1:0] act;
    logic [VALUE_WIDTH-1:0]  val;
    logic [7:0]              reps;
    logic                    fixed_exp;
    dq_result_t              exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [ACTION_WIDTH-1:0] action = '0;
  logic [VALUE_WIDTH-1:0] value_in = '0;
  logic busy;
  logic done;
  logic [VALUE_WIDTH-1:0] value_out;
  logic [STATUS_WIDTH-1:0] status;
  logic [COUNT_WIDTH-1:0] count;

  // Predictor copy of the queue contents and pointers.
  logic [VALUE_WIDTH-1:0] shadow_slots [DEPTH];
  logic [ADDR_WIDTH-1:0] shadow_front = '0;
  logic [ADDR_WIDTH-1:0] shadow_back = '0;
  int unsigned shadow_fill = 0;

  dq_result_t pending_results [$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{ACT_PEEK_FRONT, 32'h0000_0000, 8'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{ACT_PEEK_BACK,  32'h0000_0000, 8'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{ACT_POP_FRONT,  32'hFFFF_FFFF, 8'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{ACT_POP_BACK,   32'h0000_0000, 8'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{ACT_PUSH_FRONT, 32'hFFFF_FFFF, 8'd1, 1'b1, '{32'h0, ST_OK, 5'd1}},
    '{ACT_PUSH_BACK,  32'h0000_0000, 8'd1, 1'b1, '{32'h0, ST_OK, 5'd2}},
    '{ACT_PEEK_FRONT, 32'h0000_0000, 8'd1, 1'b1, '{32'hFFFF_FFFF, ST_OK, 5'd2}},
    '{ACT_PEEK_BACK,  32'hFFFF_FFFF, 8'd1, 1'b1, '{32'h0, ST_OK, 5'd2}},
    '{ACT_PUSH_FRONT, 32'h8000_0001, 8'd7, 1'b0, '{32'h0, ST_OK, 5'd0}},
    '{ACT_PUSH_BACK,  32'h7FFF_FFF0, 8'd7, 1'b0, '{32'h0, ST_OK, 5'd0}},
    '{ACT_PUSH_FRONT, 32'h1234_5678, 8'd1, 1'b1, '{32'h0, ST_FULL, 5'd16}},
    '{ACT_PUSH_BACK,  32'h1234_5678, 8'd1, 1'b1, '{32'h0, ST_FULL, 5'd16}},
    '{ACT_PEEK_FRONT, 32'h0000_0000, 8'd1, 1'b0, '{32'h0, ST_OK, 5'd0}},
    '{ACT_PEEK_BACK,  32'h0000_0000, 8'd1, 1'b0, '{32'h0, ST_OK, 5'd0}},
    '{ACT_NOP,        32'hDEAD_BEEF, 8'd1, 1'b1, '{32'h0, ST_OK, 5'd16}},
    '{ACT_POP_FRONT,  32'h0000_0000, 8'd1, 1'b0, '{32'h0, ST_OK, 5'd0}},
    '{ACT_POP_BACK,   32'h0000_0000, 8'd1, 1'b0, '{32'h0, ST_OK, 5'd0}},
    '{ACT_CLEAR,      32'hFFFF_FFFF, 8'd1, 1'b1, '{32'h0, ST_OK, 5'd0}}
  };

  double_ended_queue u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .value_in  (value_in),
    .done      (done),
    .value_out (value_out),
    .status    (status),
    .count     (count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Applies one request to the shadow queue and returns the result it should give.
  function automatic dq_result_t deque_apply(input logic [ACTION_WIDTH-1:0] act,
                                             input logic [VALUE_WIDTH-1:0] val);
    dq_result_t res;
    res = '0;
    case (act) inside
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (shadow_fill == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            shadow_front = idx_prev(shadow_front);
            shadow_slots[shadow_front] = val;
          end else begin
            shadow_slots[shadow_back] = val;
            shadow_back = idx_next(shadow_back);
          end
          shadow_fill++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else if (act == ACT_POP_FRONT) begin
          res.value = shadow_slots[shadow_front];
          shadow_front = idx_next(shadow_front);
          shadow_fill--;
        end else if (act == ACT_POP_BACK) begin
          shadow_back = idx_prev(shadow_back);
          res.value = shadow_slots[shadow_back];
          shadow_fill--;
        end else if (act == ACT_PEEK_FRONT) begin
          res.value = shadow_slots[shadow_front];
        end else begin
          res.value = shadow_slots[idx_prev(shadow_back)];
        end
      end
      ACT_CLEAR: begin
        shadow_front = '0;
        shadow_back = '0;
        shadow_fill = 0;
      end
      default: ;
    endcase
    res.count = COUNT_WIDTH'(shadow_fill);
    return res;
  endfunction

  // Drives one request, waits for the transaction and queues its expected result.
  task automatic send_request(input logic [ACTION_WIDTH-1:0] act,
                              input logic [VALUE_WIDTH-1:0] val,
                              input logic fixed_exp,
                              input dq_result_t fixed_res);
    dq_result_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    value_in <= val;
    do @(posedge clk); while (busy);
    predicted = deque_apply(act, val);
    pending_results.push_back(fixed_exp ? fixed_res : predicted);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Bursts with a push-heavy, pop-heavy or balanced mix so the queue swings
  // between empty and full and the pointers wrap many times.
  task automatic run_random(input int unsigned n_items);
    int unsigned burst_left;
    int unsigned push_pct;
    int unsigned roll;
    logic [ACTION_WIDTH-1:0] act;
    logic [VALUE_WIDTH-1:0] val;
    burst_left = 0;
    push_pct = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        act = ACT_CLEAR;
      end else if (roll < 3) begin
        act = ACT_NOP;
      end else if ($urandom_range(0, 99) < push_pct) begin
        act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      end else begin
        act = ACTION_WIDTH'($urandom_range(ACT_POP_FRONT, ACT_PEEK_BACK));
      end
      case ($urandom_range(0, 9))
        0: val = '0;
        1: val = '1;
        default: val = $urandom;
      endcase
      send_request(act, val, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    dq_result_t exp;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: value_out %h status %0d count %0d",
                 $time, value_out, status, count);
      end else begin
        exp = pending_results.pop_front();
        if (value_out !== exp.value || status !== exp.status || count !== exp.count) begin
          errors++;
          $display({"%0t: mismatch value_out exp %h act %h, status exp %0d act %0d, ",
                    "count exp %0d act %0d"},
                   $time, exp.value, value_out, exp.status, status, exp.count, count);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int i = 0; i < int'(dir_table[r].reps); i++) begin
        send_request(dir_table[r].act, dir_table[r].val + VALUE_WIDTH'(i),
                     dir_table[r].fixed_exp, dir_table[r].exp);
      end
    end
    drain_results();

    sender_idle_pct = 33;
    run_random(RAND_PER_PHASE);
    drain_results();

    sender_idle_pct = 61;
    run_random(RAND_PER_PHASE);
    drain_results();

    sender_idle_pct = 0;
    run_random(RAND_PER_PHASE);
    drain_results();

    // Any stray strobe after the last result still lands in the checker.
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue.sv
dv/double_ended_queue_tb.sv
